>>> rtl/grid_ring_nearest_match_search_unit_macros.svh
// Assertion macros used by the checker module of the search unit.
`ifndef GRID_RING_NEAREST_MATCH_SEARCH_UNIT_MACROS_SVH
`define GRID_RING_NEAREST_MATCH_SEARCH_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRNMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GRNMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/grnms_pkg.sv
package grnms_pkg;

   localparam int IDX_W      = 12;
   localparam int VALUE_W    = 8;
   localparam int RADIUS_W   = 6;
   localparam int SIDE_CFG_W = 7;

   localparam logic [SIDE_CFG_W-1:0] SIDE_RESET = 7'd64;

   typedef enum logic [0:0] {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic write;
      logic load;
      logic div_step;
      logic issue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic start_ok;
      logic div_done;
      logic gen_last;
      logic hit;
      logic pipe_empty;
   } status_type;

endpackage

>>> rtl/grnms_dp.sv
module grnms_dp #(
   parameter int MAX_SIDE  = 64,
   parameter int CELL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  grnms_pkg::cmd_type                  cmd,
   output grnms_pkg::status_type               status,
   input  logic [grnms_pkg::IDX_W-1:0]         req_cell_index,
   input  logic [grnms_pkg::VALUE_W-1:0]       req_cell_value,
   input  logic [grnms_pkg::RADIUS_W-1:0]      req_max_radius,
   input  logic                                csr_write_enable,
   input  logic [grnms_pkg::SIDE_CFG_W-1:0]    csr_write_data,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [grnms_pkg::IDX_W-1:0]         rsp_found_index
);
   import grnms_pkg::*;

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int XW     = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CW     = ((XW > RADIUS_W) ? XW : RADIUS_W) + 2;
   localparam int SQ_W   = 2 * SIDE_W;
   localparam int CMP_W  = (SQ_W > IDX_W) ? SQ_W : IDX_W;

   logic [CELL_BITS-1:0] mem [DEPTH];

   logic [SIDE_CFG_W-1:0]      map_side_ff;
   logic [SIDE_W-1:0]          side;
   logic [CMP_W-1:0]           area;

   logic [IDX_W-1:0]           rem_ff, rem_in;
   logic [XW-1:0]              y_ff, y_in;
   logic [CELL_BITS-1:0]       code_ff, code_in;
   logic [RADIUS_W-1:0]        maxr_ff, maxr_in;
   logic [RADIUS_W-1:0]        r_ff, r_in;
   logic signed [RADIUS_W:0]   dx_ff, dx_in;
   logic signed [RADIUS_W:0]   dy_ff, dy_in;

   logic signed [RADIUS_W:0]   rs;
   logic signed [RADIUS_W:0]   rs_next;
   logic [RADIUS_W-1:0]        r_inc;
   logic                       dx_border;

   logic signed [CW-1:0]       nx, ny, side_s;
   logic                       in_grid;
   logic [AW-1:0]              addr;

   logic                       s1_valid_ff, s1_valid_in;
   logic [AW-1:0]              s1_addr_ff;
   logic                       s2_valid_ff, s2_valid_in;
   logic [AW-1:0]              s2_addr_ff;
   logic [CELL_BITS-1:0]       rd_data_ff;
   logic                       hit;

   logic                       rsp_valid_ff;
   logic                       rsp_found_ff;
   logic [IDX_W-1:0]           rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_side_ff <= SIDE_RESET;
      end else if (csr_write_enable) begin
         map_side_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (map_side_ff == '0) begin
         side = SIDE_W'(1);
      end else if (32'(map_side_ff) > 32'(MAX_SIDE)) begin
         side = SIDE_W'(MAX_SIDE);
      end else begin
         side = SIDE_W'(map_side_ff);
      end
   end

   assign area = CMP_W'(side) * CMP_W'(side);

   always_comb begin
      rem_in  = rem_ff;
      y_in    = y_ff;
      code_in = code_ff;
      maxr_in = maxr_ff;
      if (cmd.load) begin
         rem_in  = req_cell_index;
         y_in    = '0;
         code_in = CELL_BITS'(req_cell_value);
         maxr_in = req_max_radius;
      end else if (cmd.div_step) begin
         rem_in = rem_ff - IDX_W'(side);
         y_in   = y_ff + XW'(1);
      end
   end

   assign rs        = $signed({1'b0, r_ff});
   assign r_inc     = r_ff + RADIUS_W'(1);
   assign rs_next   = $signed({1'b0, r_inc});
   assign dx_border = (dx_ff == rs) || (dx_ff == -rs);

   always_comb begin
      r_in  = r_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      if (cmd.load) begin
         r_in  = '0;
         dx_in = '0;
         dy_in = '0;
      end else if (cmd.issue) begin
         if (dy_ff == rs) begin
            if (dx_ff == rs) begin
               r_in  = r_inc;
               dx_in = -rs_next;
               dy_in = -rs_next;
            end else begin
               dx_in = dx_ff + (RADIUS_W+1)'(1);
               dy_in = -rs;
            end
         end else if (dx_border) begin
            dy_in = dy_ff + (RADIUS_W+1)'(1);
         end else begin
            dy_in = rs;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      y_ff    <= y_in;
      code_ff <= code_in;
      maxr_ff <= maxr_in;
      r_ff    <= r_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
   end

   assign side_s  = $signed(CW'(side));
   assign nx      = $signed(CW'(XW'(rem_ff))) + CW'(dx_ff);
   assign ny      = $signed(CW'(y_ff)) + CW'(dy_ff);
   assign in_grid = !nx[CW-1] && (nx < side_s) && !ny[CW-1] && (ny < side_s);
   assign addr    = AW'($unsigned(ny)) * AW'(side) + AW'($unsigned(nx));

   assign hit = s2_valid_ff && (rd_data_ff == code_ff);

   always_comb begin
      s1_valid_in = cmd.issue && in_grid;
      s2_valid_in = s1_valid_ff;
      if (cmd.finish) begin
         s1_valid_in = 1'b0;
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && (32'(req_cell_index) < 32'(DEPTH))) begin
         mem[AW'(req_cell_index)] <= CELL_BITS'(req_cell_value);
      end
      rd_data_ff <= mem[s1_addr_ff];
      s1_addr_ff <= addr;
      s2_addr_ff <= s1_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_found_ff <= hit;
         rsp_index_ff <= hit ? IDX_W'(s2_addr_ff) : '0;
      end
   end

   assign status.start_ok   = CMP_W'(rem_ff) < area;
   assign status.div_done   = rem_ff < IDX_W'(side);
   assign status.gen_last   = (r_ff == maxr_ff) && (dx_ff == rs) && (dy_ff == rs);
   assign status.hit        = hit;
   assign status.pipe_empty = !s1_valid_ff && !s2_valid_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_index_ff;

endmodule

>>> rtl/grnms_ctrl.sv
module grnms_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_opcode,
   output logic                  busy,
   output grnms_pkg::cmd_type    cmd,
   input  grnms_pkg::status_type status
);
   import grnms_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (opcode_type'(req_opcode) == OP_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = ST_DIV;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (!status.start_ok) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.div_done) begin
               state_in = ST_SCAN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.issue = 1'b1;
               if (status.gen_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (status.hit || status.pipe_empty) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> rtl/grid_ring_nearest_match_search_unit.sv
// Nearest matching cell search over a square grid of cell codes.
// Transactions enter on req_* and are accepted at a clock edge where start is high
// and busy is low. A write transaction (opcode 0) stores one cell and leaves busy low,
// so writes may be issued back to back; it gives no result.
// A search transaction raises busy, finds the start row and column by repeated
// subtraction of the grid side, then visits the start cell and every position on
// the rings of radius 1 to max_radius, one position per cycle, until a match is read;
// a start index outside the grid ends it as a miss with no walk. Every position is walked
// whether or not it lies inside the grid, and each in-grid one reads the cell memory
// through the read pipeline, which registers the address (s1) and then the data (s2).
// The result appears on rsp_* for exactly one cycle, marked by rsp_valid; busy
// falls in that same cycle. The receiver cannot stall the block.
// csr_write_enable writes the grid side; write it only while busy is low.
// Synchronous reset returns the controller to idle, drops any search in flight and
// sets the side to 64. Cell memory contents are not cleared by reset.
module grid_ring_nearest_match_search_unit #(
   parameter int MAX_SIDE  = 64,
   parameter int CELL_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_opcode,
   input  logic [grnms_pkg::IDX_W-1:0]       req_cell_index,
   input  logic [grnms_pkg::VALUE_W-1:0]     req_cell_value,
   input  logic [grnms_pkg::RADIUS_W-1:0]    req_max_radius,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [grnms_pkg::IDX_W-1:0]       rsp_found_index,
   input  logic                              csr_write_enable,
   input  logic [grnms_pkg::SIDE_CFG_W-1:0]  csr_write_data
);
   import grnms_pkg::*;

   cmd_type    cmd;
   status_type status;

   grnms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .cmd        (cmd),
      .status     (status)
   );

   grnms_dp #(
      .MAX_SIDE  (MAX_SIDE),
      .CELL_BITS (CELL_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_cell_index   (req_cell_index),
      .req_cell_value   (req_cell_value),
      .req_max_radius   (req_max_radius),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_found_index  (rsp_found_index)
   );

endmodule

>>> rtl/grnms_checker.sv
`include "grid_ring_nearest_match_search_unit_macros.svh"

module grnms_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        req_opcode,
   input logic                        rsp_valid,
   input logic                        rsp_found,
   input logic [grnms_pkg::IDX_W-1:0] rsp_found_index
);
   import grnms_pkg::*;

   `GRNMS_ASSERT_NEXT(a_search_goes_busy, clock, reset, start && !busy && req_opcode, busy, "accepted search did not raise busy")
   `GRNMS_ASSERT_NEXT(a_write_stays_idle, clock, reset, start && !busy && !req_opcode, !busy && !rsp_valid, "write transaction raised busy or gave a result")
   `GRNMS_ASSERT_SAME(a_done_gives_result, clock, reset, $fell(busy) && !$past(reset), rsp_valid, "search ended without a result")
   `GRNMS_ASSERT_SAME(a_miss_index_zero, clock, reset, rsp_valid && !rsp_found, rsp_found_index == '0, "miss reported a nonzero index")

endmodule

bind grid_ring_nearest_match_search_unit grnms_checker u_checker (.*);

>>> verif/grid_ring_nearest_match_search_unit_test.sv
`timescale 1ns / 100ps

module grid_ring_nearest_match_search_unit_test;
   import grnms_pkg::*;

   localparam int GRID_SIDE  = 64;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int FILL_CELLS = 25;
   localparam logic [SIDE_CFG_W-1:0] SIDE_PLAN [7] =
      '{7'd1, 7'd0, 7'd127, 7'd5, 7'd37, 7'd2, 7'd64};

   typedef struct {
      opcode_type            op;
      logic [IDX_W-1:0]      idx;
      logic [VALUE_W-1:0]    code;
      logic [RADIUS_W-1:0]   radius;
   } grid_cmd_type;

   typedef struct {
      logic               found;
      logic [IDX_W-1:0]   index;
   } match_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_opcode = 1'b0;
   logic [IDX_W-1:0]        req_cell_index = '0;
   logic [VALUE_W-1:0]      req_cell_value = '0;
   logic [RADIUS_W-1:0]     req_max_radius = '0;
   logic                    rsp_valid;
   logic                    rsp_found;
   logic [IDX_W-1:0]        rsp_found_index;
   logic                    csr_write_enable = 1'b0;
   logic [SIDE_CFG_W-1:0]   csr_write_data = '0;

   grid_cmd_type            pending_cmds[$];
   match_type               expected_matches[$];
   grid_cmd_type            in_flight;
   logic [VALUE_W-1:0]      grid_model [0:GRID_CELLS-1];
   logic [VALUE_W-1:0]      plan_grid [0:GRID_CELLS-1];
   bit                      plan_written [0:GRID_CELLS-1];
   logic [SIDE_CFG_W-1:0]   side_model = SIDE_RESET;
   int                      gap_left = 0;
   int                      gap_pct = 0;
   bit                      calm = 1'b0;
   int                      mismatches = 0;
   int                      cycle_count = 0;
   longint                  worst_cycles = 0;
   int                      writes_done = 0;
   int                      searches_done = 0;
   int                      hits_seen = 0;
   int                      sides_tried = 1;

   grid_ring_nearest_match_search_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_cell_index(req_cell_index),
      .req_cell_value(req_cell_value),
      .req_max_radius(req_max_radius),
      .rsp_valid(rsp_valid),
      .rsp_found(rsp_found),
      .rsp_found_index(rsp_found_index),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int used_side(input logic [SIDE_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > GRID_SIDE) return GRID_SIDE;
      return int'(v);
   endfunction

   // Largest radius a search can take before it would read a cell not yet written;
   // -1 when the start cell itself has not been written.
   function automatic int search_reach(input int idx, input int code, input int radius);
      int s, x, y, r, dx, dy, ni;
      s = used_side(side_model);
      if (idx >= s * s) return radius;
      if (!plan_written[idx]) return -1;
      if (int'(plan_grid[idx]) == code) return radius;
      x = idx % s;
      y = idx / s;
      for (r = 1; r <= radius; r++)
         for (dx = -r; dx <= r; dx++)
            for (dy = -r; dy <= r; dy++)
               if ((dx == r || dx == -r || dy == r || dy == -r) &&
                   x + dx >= 0 && x + dx < s && y + dy >= 0 && y + dy < s) begin
                  ni = (y + dy) * s + x + dx;
                  if (!plan_written[ni]) return r - 1;
                  if (int'(plan_grid[ni]) == code) return radius;
               end
      return radius;
   endfunction

   task automatic log_mismatch(input string msg);
      $display("[cycle %0d] mismatch: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic apply_grid_cmd(input grid_cmd_type c);
      int s, x, y, r, dx, dy, nx, ny;
      match_type m;
      if (c.op == OP_WRITE) begin
         grid_model[c.idx] = c.code;
         writes_done++;
         return;
      end
      s = used_side(side_model);
      m.found = 1'b0;
      m.index = '0;
      if (int'(c.idx) < s * s) begin
         x = int'(c.idx) % s;
         y = int'(c.idx) / s;
         if (grid_model[c.idx] == c.code) begin
            m.found = 1'b1;
            m.index = c.idx;
         end
         for (r = 1; !m.found && r <= int'(c.radius); r++)
            for (dx = -r; !m.found && dx <= r; dx++)
               for (dy = -r; !m.found && dy <= r; dy++) begin
                  nx = x + dx;
                  ny = y + dy;
                  if ((dx == r || dx == -r || dy == r || dy == -r) &&
                      nx >= 0 && nx < s && ny >= 0 && ny < s &&
                      grid_model[ny * s + nx] == c.code) begin
                     m.found = 1'b1;
                     m.index = IDX_W'(ny * s + nx);
                  end
               end
      end
      searches_done++;
      expected_matches.push_back(m);
   endtask

   task automatic queue_cmd(input opcode_type op, input int idx, input int code,
                            input int radius);
      grid_cmd_type c;
      c.op = op;
      c.idx = IDX_W'(idx);
      c.code = VALUE_W'(code);
      c.radius = RADIUS_W'(radius);
      pending_cmds.push_back(c);
      if (op == OP_WRITE) begin
         plan_grid[c.idx] = c.code;
         plan_written[c.idx] = 1'b1;
         worst_cycles += 12;
      end else begin
         worst_cycles += (2 * radius + 1) * (2 * radius + 1) + GRID_SIDE + 30;
      end
   endtask

   // A search whose start cell is still unwritten gets that cell written first.
   task automatic queue_search(input int idx, input int code, input int radius);
      int reach;
      reach = search_reach(idx, code, radius);
      if (reach < 0) begin
         queue_cmd(OP_WRITE, idx, code, 0);
         reach = radius;
      end
      queue_cmd(OP_SEARCH, idx, code, reach);
   endtask

   // Codes come mostly from a small alphabet so that searches hit at varied distances.
   task automatic queue_random_mix(input int n);
      int s, span, k, idx, code, radius;
      s = used_side(side_model);
      span = (s * s < FILL_CELLS) ? s * s : FILL_CELLS;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 40) begin
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, GRID_CELLS - 1)
                                              : $urandom_range(0, s * s - 1);
            code = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 15);
            queue_cmd(OP_WRITE, idx, code, $urandom_range(0, 63));
         end else begin
            if ($urandom_range(0, 1) == 0)
               idx = $urandom_range(0, span - 1);
            else
               idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, GRID_CELLS - 1)
                                                 : $urandom_range(0, s * s - 1);
            code = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 15);
            radius = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 4);
            queue_search(idx, code, radius);
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_matches.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_side(input logic [SIDE_CFG_W-1:0] v);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      side_model = v;
      sides_tried++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) apply_grid_cmd(in_flight);
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               in_flight = pending_cmds.pop_front();
               req_opcode <= in_flight.op;
               req_cell_index <= in_flight.idx;
               req_cell_value <= in_flight.code;
               req_max_radius <= in_flight.radius;
               start <= 1'b1;
               if (!calm && $urandom_range(0, 99) < gap_pct)
                  gap_left = $urandom_range(1, 10);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_watch
      match_type m;
      if (!reset && rsp_valid) begin
         if (expected_matches.size() == 0) begin
            log_mismatch("result with no search transaction outstanding");
         end else begin
            m = expected_matches.pop_front();
            if (rsp_found !== m.found)
               log_mismatch($sformatf("found is %b, predicted %b", rsp_found, m.found));
            if (rsp_found_index !== m.index)
               log_mismatch($sformatf("found_index is %0d, predicted %0d",
                                      rsp_found_index, m.index));
            if (m.found) hits_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * worst_cycles + 50000) begin
         $display("Run stopped at the cycle limit with %0d searches outstanding.",
                  expected_matches.size());
         $display("grid_ring_nearest_match_search_unit_test: errors");
         $finish;
      end
   end

   initial begin
      int k, p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The first cells cover every cell of the small sides and part of the first row
      // of the large ones; searches are kept to cells that are already written.
      gap_pct = 30;
      for (k = 0; k < FILL_CELLS; k++)
         queue_cmd(OP_WRITE, k, $urandom_range(0, 15), $urandom_range(0, 63));

      queue_cmd(OP_WRITE, 0, 8'h00, 0);
      queue_cmd(OP_WRITE, 4095, 8'hFF, 63);
      queue_cmd(OP_WRITE, 713, 8'h77, 0);
      queue_cmd(OP_WRITE, 587, 8'h77, 0);
      queue_cmd(OP_WRITE, 2080, 8'hA5, 0);
      queue_cmd(OP_WRITE, 650, 8'h01, 0);
      queue_cmd(OP_WRITE, 585, 8'h02, 0);
      queue_cmd(OP_WRITE, 649, 8'h03, 0);
      queue_search(0, 8'h00, 0);
      queue_search(4095, 8'hFF, 63);
      queue_search(2080, 8'hA5, 5);
      queue_search(650, 8'h77, 2);
      queue_search(0, 8'hFF, 63);
      queue_search(4095, 8'hEE, 63);
      queue_search(63, 8'h80, 5);
      queue_search(4032, 8'h5A, 3);
      queue_search(2080, 8'h03, 0);
      queue_random_mix(14);

      for (p = 0; p < 7; p++) begin
         set_side(SIDE_PLAN[p]);
         gap_pct = $urandom_range(0, 2) * 25;
         calm = (p == 6);
         if (used_side(side_model) < GRID_SIDE)
            queue_search(used_side(side_model) * used_side(side_model), 0, 63);
         queue_random_mix(9);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d writes and %0d searches, %0d of them matching,",
               writes_done, searches_done, hits_seen);
      $display("over %0d side settings.", sides_tried);
      if (mismatches == 0)
         $display("grid_ring_nearest_match_search_unit_test: clean");
      else
         $display("grid_ring_nearest_match_search_unit_test: errors");
      $finish;
   end

endmodule
